@@ rtl/core/bba_pkg.sv @@
// Shared types and codes for the buddy block allocator.
// No dependencies; imported by every module of the block.
package bba_pkg;

    // Level numbers cover up to sixteen levels.
    typedef logic [3:0] level_t;

    // One entry of the block store, one per minimum-size unit.
    typedef struct packed {
        logic   start;
        level_t level;
        logic   used;
    } entry_t;

    // Size decode handed from the decoder to the controller.
    typedef struct packed {
        logic   bad;
        level_t need;
    } size_info_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_SPLIT,
        S_FCHK,
        S_MRD,
        S_MCHK,
        S_FWR,
        S_DONE
    } state_t;

endpackage

@@ rtl/core/bba_size_decode.sv @@
// Size decoder: adds the header and picks the smallest fitting level.
// Depends on bba_pkg.
module bba_size_decode
    import bba_pkg::*;
#(
    parameter int NUM_LEVELS     = 8,
    parameter int MIN_BLOCK_LOG2 = 5,
    parameter int HEADER_BYTES   = 24
)
(
    input  logic [15:0] req_size,
    output size_info_t  info
);

    localparam logic [31:0] PageBytes = 32'd1 << (MIN_BLOCK_LOG2 + NUM_LEVELS - 1);

    logic [31:0] total;

    assign total = {16'd0, req_size} + HEADER_BYTES;

    // Scan from the top down so the smallest fitting level wins.
    always_comb
    begin
        info.bad  = (req_size == 16'd0) || (total > PageBytes);
        info.need = level_t'(NUM_LEVELS - 1);
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if ((32'd1 << (l + MIN_BLOCK_LOG2)) >= total)
            begin
                info.need = level_t'(l);
            end
        end
    end

endmodule

@@ rtl/core/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: controller and block store.
// Depends on bba_pkg and bba_size_decode.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  request  | in_valid, in_stall, cmd, req_size,        | in
//           | user_address                              |
//  result   | out_valid, out_stall, status,             | out
//           | result_address, granted_level             |
//  config   | cfg_valid, cfg_ready, cfg_data            | in
//
// One word at a time; in_stall is high outside the idle state. An allocate scans the
// store with one read per cycle at steps of the needed block size, then writes one
// entry per split plus one to mark the block, then passes through the done state.
// A bad size goes straight to the done state. A free reads and checks the entry,
// then reads and checks each buddy (each merge plus a final failed one), or only
// reads it once the block reaches page size, then writes back and finishes in done.
// After reset a clearing pass over all NUM_PAGES * 2^(NUM_LEVELS-1) entries (512 by
// default) rebuilds the store; requests stall during it.
// A finished result waits in the done state while the output register is stalled.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_PAGES      = 4,
    parameter int NUM_LEVELS     = 8,
    parameter int MIN_BLOCK_LOG2 = 5,
    parameter int HEADER_BYTES   = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] req_size,
    input  logic [13:0] user_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [13:0] result_address,
    output logic [2:0]  granted_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);

    localparam int     TopLevel  = NUM_LEVELS - 1;
    localparam int     TotalU    = NUM_PAGES << TopLevel;
    localparam int     UIW       = $clog2(TotalU);
    localparam level_t TopLvl    = level_t'(TopLevel);

    state_t state_reg, state_next;

    // Block store.
    entry_t mem [TotalU];
    entry_t rd_data;
    logic   wr_en;
    logic [UIW-1:0] wr_addr, rd_addr;
    entry_t wr_data;

    logic [2:0]     pages_reg;
    logic [UIW-1:0] clr_reg, clr_next;
    logic [UIW:0]   cnt_reg, cnt_next;
    logic           rd_vld_reg, rd_vld_next;
    logic [UIW-1:0] rd_u_reg, rd_u_next;
    logic           found_reg, found_next;
    level_t         lvl_reg, lvl_next;
    logic [UIW-1:0] u_reg, u_next;
    level_t         need_reg, need_next;
    logic [1:0]     res_st_reg, res_st_next;
    logic [13:0]    res_addr_reg, res_addr_next;
    logic [2:0]     res_lvl_reg, res_lvl_next;
    logic           out_valid_reg;
    logic [1:0]     status_reg;
    logic [13:0]    result_address_reg;
    logic [2:0]     granted_level_reg;

    size_info_t     sinfo;
    logic [UIW:0]   limit;
    logic [2:0]     pages_cl;
    logic [31:0]    fstart;
    logic           free_ok;
    logic [UIW-1:0] free_u;
    logic [UIW-1:0] bud;
    logic           bud_free;
    logic           scan_hit;
    logic [31:0]    res_full;
    logic           accept;
    logic           out_free;

    bba_size_decode #(
        .NUM_LEVELS     (NUM_LEVELS),
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
        .HEADER_BYTES   (HEADER_BYTES)
    ) u_size (
        .req_size (req_size),
        .info     (sinfo)
    );

    // Handshake and shared decodes.
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign pages_cl = ({29'd0, pages_reg} > NUM_PAGES) ? 3'(NUM_PAGES) : pages_reg;
    assign limit    = (UIW+1)'({29'd0, pages_cl} << TopLevel);

    // Free address checks: header, unit alignment and pool range.
    assign fstart  = {18'd0, user_address} - HEADER_BYTES;
    assign free_ok = ({18'd0, user_address} >= HEADER_BYTES) &&
                     ((fstart & ((32'd1 << MIN_BLOCK_LOG2) - 32'd1)) == 32'd0) &&
                     ((fstart >> MIN_BLOCK_LOG2) < TotalU);
    assign free_u  = UIW'(fstart >> MIN_BLOCK_LOG2);

    assign bud      = u_reg ^ (UIW'(1) << lvl_reg);
    assign bud_free = rd_data.start && !rd_data.used && (rd_data.level == lvl_reg);
    assign scan_hit = rd_vld_reg && rd_data.start && !rd_data.used &&
                      (rd_data.level >= need_reg) &&
                      (!found_reg || (rd_data.level < lvl_reg));
    assign res_full = ({{(32-UIW){1'b0}}, u_reg} << MIN_BLOCK_LOG2) + HEADER_BYTES;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_reg == UIW'(TotalU - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_FREE)
                    begin
                        state_next = free_ok ? S_FCHK : S_DONE;
                    end
                    else
                    begin
                        state_next = sinfo.bad ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if ((cnt_reg >= limit) && !rd_vld_reg)
                begin
                    state_next = found_reg ? S_SPLIT : S_DONE;
                end
            end
            S_SPLIT:
            begin
                if (lvl_reg <= need_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_FCHK:
            begin
                state_next = (rd_data.start && rd_data.used) ? S_MRD : S_DONE;
            end
            S_MRD:
            begin
                state_next = (lvl_reg == TopLvl) ? S_FWR : S_MCHK;
            end
            S_MCHK:
            begin
                state_next = bud_free ? S_MRD : S_FWR;
            end
            S_FWR:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and store access for each state.
    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = u_reg;
        wr_data       = '0;
        rd_addr       = free_u;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_u_next     = rd_u_reg;
        found_next    = found_reg;
        lvl_next      = lvl_reg;
        u_next        = u_reg;
        need_next     = need_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        res_lvl_next  = res_lvl_reg;
        case (state_reg)
            S_CLR:
            begin
                // Rebuild one entry per cycle: a free top block at each page start.
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data.start = (clr_reg[TopLevel-1:0] == '0);
                wr_data.level = wr_data.start ? TopLvl : '0;
                wr_data.used  = 1'b0;
                clr_next = clr_reg + UIW'(1);
            end
            S_IDLE:
            begin
                // The store read for a free goes out in the accept cycle.
                rd_addr       = free_u;
                need_next     = sinfo.need;
                cnt_next      = '0;
                found_next    = 1'b0;
                u_next        = free_u;
                res_addr_next = '0;
                res_lvl_next  = '0;
                if (cmd == CMD_FREE)
                begin
                    res_st_next = ST_BAD_FREE;
                end
                else
                begin
                    res_st_next = ST_BAD_SIZE;
                end
            end
            S_SCAN:
            begin
                // One read per cycle at steps of the needed block size.
                rd_addr = cnt_reg[UIW-1:0];
                if (cnt_reg < limit)
                begin
                    rd_vld_next = 1'b1;
                    rd_u_next   = cnt_reg[UIW-1:0];
                    cnt_next    = cnt_reg + ((UIW+1)'(1) << need_reg);
                end
                if (scan_hit)
                begin
                    found_next = 1'b1;
                    lvl_next   = rd_data.level;
                    u_next     = rd_u_reg;
                end
                res_st_next = ST_NO_SPACE;
            end
            S_SPLIT:
            begin
                // Keep the lower half free and go on in the upper half; at the needed level mark the block used.
                wr_en = 1'b1;
                if (lvl_reg > need_reg)
                begin
                    wr_data.start = 1'b1;
                    wr_data.level = lvl_reg - level_t'(1);
                    wr_data.used  = 1'b0;
                    u_next   = u_reg + (UIW'(1) << (lvl_reg - level_t'(1)));
                    lvl_next = lvl_reg - level_t'(1);
                end
                else
                begin
                    wr_data.start = 1'b1;
                    wr_data.level = lvl_reg;
                    wr_data.used  = 1'b1;
                    res_st_next   = ST_OK;
                    res_addr_next = res_full[13:0];
                    res_lvl_next  = lvl_reg[2:0];
                end
            end
            S_FCHK:
            begin
                lvl_next = rd_data.level;
            end
            S_MRD:
            begin
                rd_addr = bud;
            end
            S_MCHK:
            begin
                // Merge with a free buddy: the upper start disappears.
                if (bud_free)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = (bud > u_reg) ? bud : u_reg;
                    wr_data  = '0;
                    u_next   = (bud < u_reg) ? bud : u_reg;
                    lvl_next = lvl_reg + level_t'(1);
                end
            end
            S_FWR:
            begin
                wr_en         = 1'b1;
                wr_data.start = 1'b1;
                wr_data.level = lvl_reg;
                wr_data.used  = 1'b0;
                res_st_next   = ST_OK;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Block store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            pages_reg     <= 3'd4;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            rd_vld_reg <= rd_vld_next;
            found_reg  <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                pages_reg <= cfg_data;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        rd_u_reg     <= rd_u_next;
        lvl_reg      <= lvl_next;
        u_reg        <= u_next;
        need_reg     <= need_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        res_lvl_reg  <= res_lvl_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            status_reg         <= res_st_reg;
            result_address_reg <= res_addr_reg;
            granted_level_reg  <= res_lvl_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_address = result_address_reg;
    assign granted_level  = granted_level_reg;

    // The scan only reads; it never writes the store.
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !wr_en)
        else $error("store written during scan");

    // Splitting never goes below the needed level.
    a_split_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (lvl_reg >= need_reg))
        else $error("split below needed level");

    // A merge step always climbs exactly one level.
    a_merge_climb: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MCHK) && bud_free) |=> (lvl_reg == $past(lvl_reg) + level_t'(1)))
        else $error("merge did not climb one level");

endmodule
